// ===== rtl/mde_pkg.sv =====
package mde_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_e;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [31:0] IV_WORDS [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [4:0] round_shift(input logic [5:0] r);
    logic [4:0] s;
    s = 5'd0;
    case ({r[5:4], r[1:0]})
      4'b0000: s = 5'd7;
      4'b0001: s = 5'd12;
      4'b0010: s = 5'd17;
      4'b0011: s = 5'd22;
      4'b0100: s = 5'd5;
      4'b0101: s = 5'd9;
      4'b0110: s = 5'd14;
      4'b0111: s = 5'd20;
      4'b1000: s = 5'd4;
      4'b1001: s = 5'd11;
      4'b1010: s = 5'd16;
      4'b1011: s = 5'd23;
      4'b1100: s = 5'd6;
      4'b1101: s = 5'd10;
      4'b1110: s = 5'd15;
      4'b1111: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] g;
    g = 4'd0;
    case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
      2'd2: g = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
      2'd3: g = 4'((r[3:0] << 3) - r[3:0]);
      default: g = 4'd0;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] x;
    x = {v, v} << s;
    return x[63:32];
  endfunction

endpackage

// ===== rtl/md5_digest_engine_unit.sv =====
// channel   | dir | tdata              | tuser          | tlast
// s_axis    | in  | message_byte [7:0] | opcode [0]     | -
// m_axis    | out | digest_word [31:0] | word_index [1:0] | last_word
//
// an absorb item writes one byte into the block store; the item that fills byte 63 of the block
// starts the compression (one round per cycle, then the chain add)
// a finish item writes one padding byte per cycle through the block store,
// runs one or two compressions, then hands out four words over the output register
// reset returns the chain words to the initial vector and clears the counters
// the output register lets a new item in while the last word still waits
module md5_digest_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // message_byte
  input  logic [0:0]  s_axis_tuser_i,   // opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // digest_word
  output logic [1:0]  m_axis_tuser_o,   // word_index
  output logic        m_axis_tlast_o
);

  mde_pkg::state_e state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bit_cnt_q, bit_cnt_d;
  logic        fin_q, fin_d;
  logic        lenph_q, lenph_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [1:0]  out_idx_q, out_idx_d;
  logic [31:0] h_q [4];
  logic [31:0] h_d [4];
  logic        m_valid_q, m_valid_d;

  logic [31:0] mem_q [16];
  logic [31:0] rd_q;
  logic [3:0]  rd_addr;

  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] m_data_q;
  logic [1:0]  m_user_q;
  logic        m_last_q;

  logic        put_en;
  logic [7:0]  put_data;
  logic        cmp_start;
  logic        out_load;
  logic        accept;

  logic [31:0] f_val;
  logic [31:0] t_val;
  logic [31:0] b_new;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == mde_pkg::ST_IDLE);

  // round function
  always_comb begin
    f_val = 32'd0;
    case (rnd_q[5:4])
      2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1: f_val = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f_val = b_q ^ c_q ^ d_q;
      2'd3: f_val = c_q ^ (b_q | ~d_q);
      default: f_val = 32'd0;
    endcase
    t_val = a_q + f_val + mde_pkg::ROUND_K[rnd_q] + rd_q;
    b_new = b_q + mde_pkg::rotl32(t_val, mde_pkg::round_shift(rnd_q));
  end

  assign rd_addr = (state_q == mde_pkg::ST_ROUND) ? mde_pkg::msg_index(rnd_q + 6'd1) : 4'd0;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    bit_cnt_d = bit_cnt_q;
    fin_d     = fin_q;
    lenph_d   = lenph_q;
    rnd_d     = rnd_q;
    out_idx_d = out_idx_q;
    h_d       = h_q;
    m_valid_d = m_valid_q;
    put_en    = 1'b0;
    put_data  = 8'd0;
    out_load  = 1'b0;

    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      mde_pkg::ST_IDLE: begin
        if (accept) begin
          put_en = 1'b1;
          if (s_axis_tuser_i[0] == mde_pkg::OP_FINISH) begin
            put_data = mde_pkg::PAD_BYTE;
            fin_d    = 1'b1;
            state_d  = mde_pkg::ST_PAD;
          end else begin
            put_data  = s_axis_tdata_i;
            bit_cnt_d = bit_cnt_q + 64'd8;
          end
        end
      end
      mde_pkg::ST_PAD: begin
        put_en = 1'b1;
        if (lenph_q || fill_q == mde_pkg::LEN_POS) begin
          lenph_d  = 1'b1;
          put_data = bit_cnt_q[{fill_q[2:0], 3'b000} +: 8];
        end
      end
      mde_pkg::ST_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == mde_pkg::LAST_POS) begin
          state_d = mde_pkg::ST_FINAL;
        end
      end
      mde_pkg::ST_FINAL: begin
        h_d[0] = h_q[0] + a_q;
        h_d[1] = h_q[1] + b_q;
        h_d[2] = h_q[2] + c_q;
        h_d[3] = h_q[3] + d_q;
        if (!fin_q) begin
          state_d = mde_pkg::ST_IDLE;
        end else if (lenph_q) begin
          state_d = mde_pkg::ST_EMIT;
        end else begin
          state_d = mde_pkg::ST_PAD;
        end
      end
      mde_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          out_idx_d = out_idx_q + 2'd1;
          if (out_idx_q == 2'd3) begin
            state_d   = mde_pkg::ST_IDLE;
            h_d       = mde_pkg::IV_WORDS;
            fill_d    = 6'd0;
            bit_cnt_d = 64'd0;
            fin_d     = 1'b0;
            lenph_d   = 1'b0;
          end
        end
      end
      default: state_d = mde_pkg::ST_IDLE;
    endcase

    cmp_start = put_en && (fill_q == mde_pkg::LAST_POS);
    if (put_en) begin
      fill_d = fill_q + 6'd1;
      if (cmp_start) begin
        state_d = mde_pkg::ST_ROUND;
        rnd_d   = 6'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mde_pkg::ST_IDLE;
      fill_q    <= 6'd0;
      bit_cnt_q <= 64'd0;
      fin_q     <= 1'b0;
      lenph_q   <= 1'b0;
      rnd_q     <= 6'd0;
      out_idx_q <= 2'd0;
      h_q       <= mde_pkg::IV_WORDS;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      bit_cnt_q <= bit_cnt_d;
      fin_q     <= fin_d;
      lenph_q   <= lenph_d;
      rnd_q     <= rnd_d;
      out_idx_q <= out_idx_d;
      h_q       <= h_d;
      m_valid_q <= m_valid_d;
    end
  end

  // block store, byte writes, registered word read
  always_ff @(posedge clk_i) begin
    if (put_en) begin
      mem_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= put_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // working words and output register
  always_ff @(posedge clk_i) begin
    if (cmp_start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
    end else if (state_q == mde_pkg::ST_ROUND) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_new;
    end
    if (out_load) begin
      m_data_q <= h_q[out_idx_q];
      m_user_q <= out_idx_q;
      m_last_q <= (out_idx_q == 2'd3);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ===== tb/md5_digest_engine_unit_test.sv =====
`timescale 1ns / 100ps

module md5_digest_engine_unit_test;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned ITEM_TARGET = 410;
  localparam int unsigned DIGEST_TARGET = 12;
  localparam int unsigned PLAN_LEN = 15;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROT_AMOUNT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  localparam logic [127:0] DIGEST_EMPTY =
    {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4};
  localparam logic [127:0] DIGEST_A =
    {32'h61267769, 32'he299c331, 32'ha8b6f1c0, 32'hb975c10c};
  localparam logic [127:0] DIGEST_ABC =
    {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190};

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_word_t;

  typedef struct packed {
    logic         op;
    logic [7:0]   msg_byte;
    logic         typed;
    logic [127:0] digest;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // message_byte
  logic [0:0]  s_axis_tuser_i;   // opcode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // digest_word
  logic [1:0]  m_axis_tuser_o;   // word_index
  logic        m_axis_tlast_o;

  logic [31:0] chain_w [4];
  logic [7:0]  block_b [64];
  logic [5:0]  fill_pos;
  logic [63:0] bit_len;

  digest_word_t digest_q [$];
  plan_row_t    plan [PLAN_LEN];
  int unsigned  fail_count = 0;
  int unsigned  item_count = 0;
  int unsigned  digest_count = 0;
  int unsigned  idle_cycles = 0;
  bit           calm = 1'b0;
  bit           hold = 1'b0;

  md5_digest_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void pred_clear();
    chain_w[0] = 32'h67452301;
    chain_w[1] = 32'hefcdab89;
    chain_w[2] = 32'h98badcfe;
    chain_w[3] = 32'h10325476;
    fill_pos = 6'd0;
    bit_len = 64'd0;
  endfunction

  function automatic void md5_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int g, s;
    for (int k = 0; k < 16; k++) begin
      w[k] = {block_b[4*k+3], block_b[4*k+2], block_b[4*k+1], block_b[4*k]};
    end
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = a + f + SINE_K[r] + w[g];
      s = ROT_AMOUNT[(r / 16) * 4 + r % 4];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    chain_w[0] = chain_w[0] + a;
    chain_w[1] = chain_w[1] + b;
    chain_w[2] = chain_w[2] + c;
    chain_w[3] = chain_w[3] + d;
  endfunction

  function automatic void md5_put_byte(input logic [7:0] v);
    block_b[fill_pos] = v;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) begin
      md5_compress();
    end
  endfunction

  // absorb one byte, or pad and, when push is set, queue the four digest words
  function automatic void md5_step(input logic op, input logic [7:0] v, input bit push);
    logic [63:0] len;
    if (op == mde_pkg::OP_ABSORB) begin
      bit_len = bit_len + 64'd8;
      md5_put_byte(v);
      return;
    end
    len = bit_len;
    md5_put_byte(8'h80);
    while (fill_pos != 6'd56) begin
      md5_put_byte(8'h00);
    end
    for (int k = 0; k < 8; k++) begin
      md5_put_byte(len[8*k +: 8]);
    end
    if (push) begin
      for (int k = 0; k < 4; k++) begin
        digest_q.push_back('{chain_w[k], 2'(k), k == 3});
      end
    end
    pred_clear();
  endfunction

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic send_item(input logic op, input logic [7:0] v, input bit push);
    int gap;
    gap = draw_gap();
    if (hold && gap == 0) begin
      gap = 1;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      while (hold && digest_q.size() != 0) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= v;
    s_axis_tuser_i <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    md5_step(op, v, push);
    item_count++;
    if (op == mde_pkg::OP_FINISH) begin
      digest_count++;
    end
    hold = 1'b0;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_item(mde_pkg::OP_ABSORB, 8'($urandom_range(0, 255)), 1'b1);
    end
    send_item(mde_pkg::OP_FINISH, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic int draw_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      return $urandom_range(0, 6);
    end else if (pick < 75) begin
      return $urandom_range(52, 68);
    end else if (pick < 90) begin
      return $urandom_range(116, 132);
    end
    return $urandom_range(7, 51);
  endfunction

  // output side
  initial begin
    int gap;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    digest_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest item exp none got %h/%0d/%b", $time,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata_o !== want.word) begin
          $display("%0t: digest_word mismatch exp %h got %h", $time, want.word, m_axis_tdata_o);
          fail_count++;
        end
        if (m_axis_tuser_o !== want.index) begin
          $display("%0t: word_index mismatch exp %0d got %0d", $time, want.index,
                   m_axis_tuser_o);
          fail_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t: last_word mismatch exp %b got %b", $time, want.last, m_axis_tlast_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("md5_digest_engine_unit_test: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = 8'h00;
    s_axis_tuser_i = mde_pkg::OP_ABSORB;
    pred_clear();
    plan = '{
      '{mde_pkg::OP_FINISH, 8'h00, 1'b1, DIGEST_EMPTY},
      '{mde_pkg::OP_FINISH, 8'hff, 1'b1, DIGEST_EMPTY},
      '{mde_pkg::OP_ABSORB, 8'h61, 1'b0, 128'd0},
      '{mde_pkg::OP_FINISH, 8'h5a, 1'b1, DIGEST_A},
      '{mde_pkg::OP_ABSORB, 8'h61, 1'b0, 128'd0},
      '{mde_pkg::OP_ABSORB, 8'h62, 1'b0, 128'd0},
      '{mde_pkg::OP_ABSORB, 8'h63, 1'b0, 128'd0},
      '{mde_pkg::OP_FINISH, 8'ha5, 1'b1, DIGEST_ABC},
      '{mde_pkg::OP_ABSORB, 8'h00, 1'b0, 128'd0},
      '{mde_pkg::OP_ABSORB, 8'hff, 1'b0, 128'd0},
      '{mde_pkg::OP_ABSORB, 8'h80, 1'b0, 128'd0},
      '{mde_pkg::OP_FINISH, 8'h00, 1'b0, 128'd0},
      '{mde_pkg::OP_ABSORB, 8'hff, 1'b0, 128'd0},
      '{mde_pkg::OP_ABSORB, 8'h01, 1'b0, 128'd0},
      '{mde_pkg::OP_FINISH, 8'hff, 1'b0, 128'd0}
    };
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      send_item(plan[i].op, plan[i].msg_byte, !plan[i].typed);
      if (plan[i].typed) begin
        for (int k = 0; k < 4; k++) begin
          digest_q.push_back('{plan[i].digest[32*k +: 32], 2'(k), k == 3});
        end
      end
    end

    hold = 1'b1;
    while (item_count < ITEM_TARGET || digest_count < DIGEST_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      if (digest_count == PLAN_LEN / 3 + 4) begin
        hold = 1'b1;
      end
      send_message(draw_length());
    end
    calm = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("md5_digest_engine_unit_test: PASS");
    end else begin
      $display("md5_digest_engine_unit_test: FAIL");
    end
    $finish;
  end

endmodule
